>>> rtl/grf_pkg.sv
`default_nettype none

package grf_pkg;

    // Field and datapath widths
    localparam int PIX_W     = 16;
    localparam int COEF_W    = 16;
    localparam int H_W       = 3;
    localparam int PAIR_W    = PIX_W + 1;
    localparam int PROD_W    = PAIR_W + COEF_W;
    localparam int SUM_LANES = 8;
    localparam int ACC_W     = PROD_W + 3;
    localparam int FRAC_BITS = 15;

    // Number of weight registers: center plus six sides
    localparam int NUM_COEF  = 7;
    localparam int MAX_SIDE  = NUM_COEF - 1;

    // Rounding constant: one half in Q1.15
    localparam logic [ACC_W:0] ROUND_HALF = (ACC_W + 1)'(1) << (FRAC_BITS - 1);

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_CENTER = 3'd1;

    // Register reset values
    localparam logic [H_W-1:0]    HALF_WIDTH_RESET  = 3'd1;
    localparam logic [COEF_W-1:0] COEF_CENTER_RESET = 16'h8000;

    // Stage enables for the tap lanes: pair register, product register
    typedef struct packed {
        logic pair;
        logic prod;
    } tap_en_t;

    // Stage enables for the adder tree
    typedef struct packed {
        logic lvl1;
        logic lvl2;
        logic lvl3;
    } sum_en_t;

endpackage

`default_nettype wire

>>> rtl/grf_cell.sv
`default_nettype none

// One sample of the window: loads a replicated edge value or takes its neighbor.
module grf_cell (
    input  wire logic                       clk,
    input  wire logic                       step,
    input  wire logic                       load,
    input  wire logic [grf_pkg::PIX_W-1:0]  load_val,
    input  wire logic [grf_pkg::PIX_W-1:0]  shift_val,
    output      logic [grf_pkg::PIX_W-1:0]  sample
);

    logic [grf_pkg::PIX_W-1:0] sample_reg;

    // Advance the window on each step
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            sample_reg <= load ? load_val : shift_val;
        end
    end

    assign sample = sample_reg;

endmodule

`default_nettype wire

>>> rtl/grf_tap.sv
`default_nettype none

// One kernel distance: add the mirrored pair, then weight it.
module grf_tap (
    input  wire logic                        clk,
    input  wire grf_pkg::tap_en_t            en,
    input  wire logic                        use_lane,
    input  wire logic [grf_pkg::PIX_W-1:0]   near,
    input  wire logic [grf_pkg::PIX_W-1:0]   far,
    input  wire logic [grf_pkg::COEF_W-1:0]  coef,
    output      logic [grf_pkg::PROD_W-1:0]  prod
);

    logic [grf_pkg::PAIR_W-1:0] pair_reg;
    logic [grf_pkg::PAIR_W-1:0] pair_next;
    logic [grf_pkg::PROD_W-1:0] prod_reg;

    // Drop taps beyond the active half width
    assign pair_next = use_lane
        ? (grf_pkg::PAIR_W'(near) + grf_pkg::PAIR_W'(far))
        : '0;

    always_ff @(posedge clk)
    begin
        if (en.pair)
        begin
            pair_reg <= pair_next;
        end
        if (en.prod)
        begin
            prod_reg <= grf_pkg::PROD_W'(pair_reg) * grf_pkg::PROD_W'(coef);
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

>>> rtl/grf_sum.sv
`default_nettype none

// Registered three-level adder tree over the eight product lanes.
module grf_sum (
    input  wire logic                        clk,
    input  wire grf_pkg::sum_en_t            en,
    input  wire logic [grf_pkg::PROD_W-1:0]  prod [grf_pkg::SUM_LANES],
    output      logic [grf_pkg::ACC_W-1:0]   acc
);

    logic [grf_pkg::ACC_W-1:0] lvl1_reg [grf_pkg::SUM_LANES/2];
    logic [grf_pkg::ACC_W-1:0] lvl2_reg [grf_pkg::SUM_LANES/4];
    logic [grf_pkg::ACC_W-1:0] lvl3_reg;

    always_ff @(posedge clk)
    begin
        // First level: pairs of products
        if (en.lvl1)
        begin
            for (int i = 0; i < grf_pkg::SUM_LANES/2; i++)
            begin
                lvl1_reg[i] <= grf_pkg::ACC_W'(prod[2*i]) + grf_pkg::ACC_W'(prod[2*i+1]);
            end
        end
        // Second level
        if (en.lvl2)
        begin
            for (int i = 0; i < grf_pkg::SUM_LANES/4; i++)
            begin
                lvl2_reg[i] <= lvl1_reg[2*i] + lvl1_reg[2*i+1];
            end
        end
        // Final sum
        if (en.lvl3)
        begin
            lvl3_reg <= lvl2_reg[0] + lvl2_reg[1];
        end
    end

    assign acc = lvl3_reg;

endmodule

`default_nettype wire

>>> rtl/gaussian_row_filter_replicate_unit.sv
`default_nettype none

// Horizontal symmetric FIR over image rows with edge replication. Pixels enter
// one per clock on the slave stream while s_tready is high; tlast marks the
// last pixel of a row. Each row is filtered with 2*h+1 taps (h = half_width
// clamped to 1..min(MAX_HALF,7), weights beyond distance 6 are zero) and one
// result leaves per pixel, lagging by h pixels. After a row's last pixel the
// input is held while the window shifts in h copies of that pixel, which
// flushes the pending results; the final one carries tlast. m_tvalid follows
// the window step that produces a result through the pair add, multiply, three
// adder levels and the round/saturate output register. Results are
// round-half-up of the Q1.15 sum, saturated to 65535. Write configuration
// only while no transaction is in flight.
module gaussian_row_filter_replicate_unit #(
    parameter int MAX_HALF = 6
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Configuration write port
    input  wire logic                            cfg_we,
    input  wire logic [grf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [grf_pkg::COEF_W-1:0]      cfg_data,
    // Pixel input stream
    input  wire logic                            s_tvalid,
    output      logic                            s_tready,
    input  wire logic [15:0]                     s_tdata,   // [15:0] pixel_in
    input  wire logic                            s_tlast,   // last_in_row
    // Filtered output stream
    output      logic                            m_tvalid,
    input  wire logic                            m_tready,
    output      logic [15:0]                     m_tdata,   // [15:0] pixel_out
    output      logic                            m_tlast    // last_out
);

    // Largest usable half width and largest weighted distance
    localparam int HMAX    = (MAX_HALF < 7) ? MAX_HALF : 7;
    localparam int TMAX    = (MAX_HALF < grf_pkg::MAX_SIDE) ? MAX_HALF : grf_pkg::MAX_SIDE;
    localparam int NT      = TMAX + 1;
    localparam int WIN_LEN = HMAX + TMAX + 1;
    localparam int IDX_W   = $clog2(WIN_LEN + TMAX);
    localparam int CNT_W   = $clog2(HMAX + 1);

    // Pipeline stages
    localparam int ST_WIN  = 0;
    localparam int ST_PAIR = 1;
    localparam int ST_PROD = 2;
    localparam int ST_L1   = 3;
    localparam int ST_L2   = 4;
    localparam int ST_L3   = 5;
    localparam int ST_OUT  = 6;
    localparam int NUM_ST  = 7;

    // Configuration registers
    logic [grf_pkg::H_W-1:0]    hw_reg;
    logic [grf_pkg::COEF_W-1:0] coef_reg [grf_pkg::NUM_COEF];
    logic [grf_pkg::H_W-1:0]    h_eff;

    // Row control
    logic [CNT_W-1:0]        cnt_reg;
    logic [CNT_W-1:0]        cnt_next;
    logic [CNT_W-1:0]        cnt_inc;
    logic                    flush_reg;
    logic                    flush_next;
    logic [grf_pkg::H_W-1:0] rem_reg;
    logic [grf_pkg::H_W-1:0] rem_next;
    logic                    accept;
    logic                    flush_step;
    logic                    step;
    logic                    row_start;
    logic                    fire;
    logic                    final_step;

    // Pipeline occupancy
    logic [NUM_ST-1:0] v_reg;
    logic [NUM_ST-1:0] l_reg;
    logic [NUM_ST-1:0] en;

    // Datapath
    logic [grf_pkg::PIX_W-1:0]  win [WIN_LEN];
    logic [grf_pkg::PIX_W-1:0]  step_px;
    logic [grf_pkg::PROD_W-1:0] prod [grf_pkg::SUM_LANES];
    logic [grf_pkg::ACC_W-1:0]  acc;
    logic [grf_pkg::ACC_W:0]    rounded;
    logic [grf_pkg::PIX_W-1:0]  pix_sat;
    logic [grf_pkg::PIX_W-1:0]  pixel_reg;
    grf_pkg::tap_en_t           tap_en;
    grf_pkg::sum_en_t           sum_en;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hw_reg <= grf_pkg::HALF_WIDTH_RESET;
            coef_reg[0] <= grf_pkg::COEF_CENTER_RESET;
            for (int d = 1; d < grf_pkg::NUM_COEF; d++)
            begin
                coef_reg[d] <= '0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == grf_pkg::REG_HALF_WIDTH)
            begin
                hw_reg <= cfg_data[grf_pkg::H_W-1:0];
            end
            for (int d = 0; d < grf_pkg::NUM_COEF; d++)
            begin
                if (cfg_index == grf_pkg::REG_COEF_CENTER + grf_pkg::CFG_IDX_W'(d))
                begin
                    coef_reg[d] <= cfg_data;
                end
            end
        end
    end

    // Clamp the half width into the supported range
    always_comb
    begin
        priority if (hw_reg == '0)
        begin
            h_eff = grf_pkg::H_W'(1);
        end
        else if (hw_reg > grf_pkg::H_W'(HMAX))
        begin
            h_eff = grf_pkg::H_W'(HMAX);
        end
        else
        begin
            h_eff = hw_reg;
        end
    end

    // Stall chain: a stage moves when its successor frees up
    always_comb
    begin
        en[ST_OUT] = !v_reg[ST_OUT] || m_tready;
        for (int k = NUM_ST - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign s_tready   = en[ST_WIN] && !flush_reg;
    assign accept     = s_tvalid && s_tready;
    assign flush_step = flush_reg && en[ST_WIN];
    assign step       = accept || flush_step;
    assign row_start  = accept && (cnt_reg == '0);
    assign step_px    = accept ? s_tdata : win[0];
    assign fire       = step && (grf_pkg::H_W'(cnt_reg) >= h_eff);
    assign final_step = flush_step && (rem_reg == grf_pkg::H_W'(1));

    // Row position saturates once past the largest lag
    assign cnt_inc = (cnt_reg == CNT_W'(HMAX)) ? cnt_reg : cnt_reg + CNT_W'(1);

    always_comb
    begin
        cnt_next   = cnt_reg;
        flush_next = flush_reg;
        rem_next   = rem_reg;
        if (accept)
        begin
            cnt_next = cnt_inc;
            if (s_tlast)
            begin
                flush_next = 1'b1;
                rem_next   = h_eff;
            end
        end
        else if (flush_step)
        begin
            rem_next = rem_reg - grf_pkg::H_W'(1);
            if (final_step)
            begin
                cnt_next   = '0;
                flush_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_inc;
            end
        end
    end

    // Control registers and stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            flush_reg <= 1'b0;
            rem_reg   <= '0;
            v_reg     <= '0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            flush_reg <= flush_next;
            rem_reg   <= rem_next;
            if (en[ST_WIN])
            begin
                v_reg[ST_WIN] <= fire;
            end
            for (int k = 1; k < NUM_ST; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // Row-end marks travel beside the valids
    always_ff @(posedge clk)
    begin
        if (en[ST_WIN])
        begin
            l_reg[ST_WIN] <= final_step;
        end
        for (int k = 1; k < NUM_ST; k++)
        begin
            if (en[k])
            begin
                l_reg[k] <= l_reg[k-1];
            end
        end
    end

    // Sample window: a chain of cells, newest at index 0
    for (genvar i = 0; i < WIN_LEN; i++)
    begin : g_win
        logic [grf_pkg::PIX_W-1:0] shift_val;
        if (i == 0)
        begin : g_head
            assign shift_val = step_px;
        end
        else
        begin : g_body
            assign shift_val = win[i-1];
        end
        grf_cell u_cell (
            .clk       (clk),
            .step      (step),
            .load      (row_start),
            .load_val  (s_tdata),
            .shift_val (shift_val),
            .sample    (win[i])
        );
    end

    assign tap_en.pair = en[ST_PAIR];
    assign tap_en.prod = en[ST_PROD];

    // Tap lanes, one per kernel distance
    for (genvar d = 0; d < grf_pkg::SUM_LANES; d++)
    begin : g_lane
        if (d < NT)
        begin : g_tap
            logic [grf_pkg::PIX_W-1:0] near;
            logic [grf_pkg::PIX_W-1:0] far;
            logic                      use_lane;

            // Pick the samples at h-d and h+d
            always_comb
            begin
                near = '0;
                far  = '0;
                for (int j = 0; j < WIN_LEN; j++)
                begin
                    if (IDX_W'(j + d) == IDX_W'(h_eff))
                    begin
                        near = win[j];
                    end
                    if ((d != 0) && (IDX_W'(j) == IDX_W'(h_eff) + IDX_W'(d)))
                    begin
                        far = win[j];
                    end
                end
            end

            assign use_lane = (grf_pkg::H_W'(d) <= h_eff);

            grf_tap u_tap (
                .clk      (clk),
                .en       (tap_en),
                .use_lane (use_lane),
                .near     (near),
                .far      (far),
                .coef     (coef_reg[d]),
                .prod     (prod[d])
            );
        end
        else
        begin : g_pad
            assign prod[d] = '0;
        end
    end

    assign sum_en.lvl1 = en[ST_L1];
    assign sum_en.lvl2 = en[ST_L2];
    assign sum_en.lvl3 = en[ST_L3];

    grf_sum u_sum (
        .clk  (clk),
        .en   (sum_en),
        .prod (prod),
        .acc  (acc)
    );

    // Round half up, drop the fraction, saturate
    assign rounded = {1'b0, acc} + grf_pkg::ROUND_HALF;
    assign pix_sat = (|rounded[grf_pkg::ACC_W:grf_pkg::FRAC_BITS+grf_pkg::PIX_W])
        ? '1
        : rounded[grf_pkg::FRAC_BITS+grf_pkg::PIX_W-1:grf_pkg::FRAC_BITS];

    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
        begin
            pixel_reg <= pix_sat;
        end
    end

    assign m_tvalid = v_reg[ST_OUT];
    assign m_tdata  = pixel_reg;
    assign m_tlast  = l_reg[ST_OUT];

    // A row end arms a flush of exactly h steps
    a_flush_arm : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tlast) |=> (flush_reg && (rem_reg == $past(h_eff))))
        else $error("flush not armed with the half width");

    // The final flush step returns the row to its start
    a_flush_end : assert property (@(posedge clk) disable iff (!rst_n)
        final_step |=> (!flush_reg && (cnt_reg == '0)))
        else $error("row state not cleared after flush");

    // A row start replicates the first pixel across the window
    a_row_fill : assert property (@(posedge clk) disable iff (!rst_n)
        row_start |=> ((win[0] == $past(s_tdata)) && (win[WIN_LEN-1] == $past(s_tdata))))
        else $error("window not filled at row start");

    // No transaction is accepted during the edge flush
    a_no_accept_flush : assert property (@(posedge clk) disable iff (!rst_n)
        (flush_reg && !final_step) |=> !accept)
        else $error("input accepted during flush");

endmodule

`default_nettype wire

>>> tb/tb_gaussian_row_filter_replicate_unit.sv
module tb_gaussian_row_filter_replicate_unit;

    localparam int MAX_HALF    = 6;
    localparam int MAX_ROW     = 4096;
    localparam int WIN_LEN     = 2 * MAX_HALF + 1;
    localparam int NUM_REGS    = 8;
    localparam int ITEMS       = 380;
    localparam int QUIET_TAIL  = 60;
    localparam int SETTLE      = 24;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_PRINTS  = 40;

    typedef struct {
        bit [15:0] pixel;
        bit        last;
    } filtered_t;

    // Row filter predictor with its own copy of the registers and the row window
    class row_filter_scoreboard;
        bit [grf_pkg::H_W-1:0]    half_width;
        bit [grf_pkg::COEF_W-1:0] weight [0:MAX_HALF];
        bit [15:0]                window [0:WIN_LEN-1];
        int unsigned              row_pos;
        filtered_t                expected_pixels [$];
        int unsigned              errors;

        function new();
            half_width = grf_pkg::HALF_WIDTH_RESET;
            foreach (weight[i]) weight[i] = '0;
            weight[0] = grf_pkg::COEF_CENTER_RESET;
            foreach (window[i]) window[i] = '0;
            row_pos = 0;
            errors  = 0;
        endfunction

        task flag_mismatch(input string msg);
            errors++;
            if (errors <= MAX_PRINTS)
                $display("ERROR at %0t: %s", $time, msg);
        endtask

        function void set_register(input bit [grf_pkg::CFG_IDX_W-1:0] idx,
                                   input bit [15:0] value);
            if (idx == grf_pkg::REG_HALF_WIDTH)
                half_width = value[grf_pkg::H_W-1:0];
            else
                weight[idx - grf_pkg::REG_COEF_CENTER] = value;
        endfunction

        function void shift_window(input bit [15:0] px);
            for (int k = WIN_LEN - 1; k > 0; k--)
                window[k] = window[k - 1];
            window[0] = px;
        endfunction

        // Weighted sum around the center tap, rounded half up and saturated
        function bit [15:0] filter_at(input int h);
            bit [63:0] acc;
            acc = 64'(window[h]) * 64'(weight[0]);
            for (int d = 1; d <= h; d++)
                acc += (64'(window[h - d]) + 64'(window[h + d])) * 64'(weight[d]);
            acc = (acc + 64'd16384) >> 15;
            return (acc > 64'd65535) ? 16'hFFFF : acc[15:0];
        endfunction

        function void push_expected(input bit [15:0] px, input bit last);
            filtered_t r;
            r.pixel = px;
            r.last  = last;
            expected_pixels.push_back(r);
        endfunction

        // Note an accepted pixel and queue the results it releases
        function void take_pixel(input bit [15:0] px, input bit last);
            int h;
            int unsigned pos;
            h = half_width;
            if (h < 1) h = 1;
            if (h > MAX_HALF) h = MAX_HALF;
            pos = row_pos;
            if (pos == 0)
                foreach (window[i]) window[i] = px;
            else
                shift_window(px);
            if (pos >= h)
                push_expected(filter_at(h), 1'b0);
            if (last)
            begin
                // Flush: replicate the last pixel past the row end
                for (int s = 1; s <= h; s++)
                begin
                    shift_window(px);
                    if (pos + s >= h)
                        push_expected(filter_at(h), s == h);
                end
                row_pos = 0;
            end
            else if (pos < MAX_ROW - 1)
            begin
                row_pos = pos + 1;
            end
        endfunction

        // Compare one output transaction with the oldest expectation
        task check_pixel(input logic [15:0] px, input logic last);
            filtered_t want;
            if (expected_pixels.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected result pixel=%h last=%b", px, last));
                return;
            end
            want = expected_pixels.pop_front();
            if (px !== want.pixel)
                flag_mismatch($sformatf("pixel_out %h, expected %h", px, want.pixel));
            if (last !== want.last)
                flag_mismatch($sformatf("last_out %b, expected %b (pixel %h)",
                                        last, want.last, want.pixel));
        endtask

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [grf_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [grf_pkg::COEF_W-1:0]    cfg_data;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [15:0]                   s_tdata;   // [15:0] pixel_in
    logic                          s_tlast;   // last_in_row
    logic                          m_tvalid;
    logic                          m_tready;
    logic [15:0]                   m_tdata;   // [15:0] pixel_out
    logic                          m_tlast;   // last_out

    row_filter_scoreboard sb;
    bit                   src_idle_on;
    bit                   sink_idle_on;
    bit                   quiet;
    int                   cycles;

    gaussian_row_filter_replicate_unit #(
        .MAX_HALF(MAX_HALF)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watch both streams at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.take_pixel(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                sb.check_pixel(m_tdata, m_tlast);
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver: ready with random stall bursts, none in the tail of the run
    initial
    begin
        int stall_left;
        int span;
        m_tready     = 1'b0;
        stall_left   = 0;
        span         = 0;
        sink_idle_on = 1'b0;
        forever
        begin
            @(negedge clk);
            if (span == 0)
            begin
                sink_idle_on = $urandom_range(0, 2) != 0;
                span         = $urandom_range(50, 300);
            end
            span--;
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (sink_idle_on && !quiet && $urandom_range(0, 11) == 0)
            begin
                stall_left = $urandom_range(0, 11);
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Drive one pixel transaction, with an optional gap ahead of it
    task send_pixel(input bit [15:0] px, input bit last);
        if (src_idle_on && !quiet && $urandom_range(0, 9) == 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(0, 11)) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
    endtask

    // Hold the input until every expected result is out, then let the pipe empty
    task drain_block();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Write half width and all seven weights, one register per cycle
    task load_kernel(input bit [15:0] h, input bit [15:0] c0, input bit [15:0] c1,
                     input bit [15:0] c2, input bit [15:0] c3, input bit [15:0] c4,
                     input bit [15:0] c5, input bit [15:0] c6);
        bit [15:0] image [0:NUM_REGS-1];
        image[grf_pkg::REG_HALF_WIDTH]      = h;
        image[grf_pkg::REG_COEF_CENTER]     = c0;
        image[grf_pkg::REG_COEF_CENTER + 1] = c1;
        image[grf_pkg::REG_COEF_CENTER + 2] = c2;
        image[grf_pkg::REG_COEF_CENTER + 3] = c3;
        image[grf_pkg::REG_COEF_CENTER + 4] = c4;
        image[grf_pkg::REG_COEF_CENTER + 5] = c5;
        image[grf_pkg::REG_COEF_CENTER + 6] = c6;
        for (int i = 0; i < NUM_REGS; i++)
        begin
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= grf_pkg::CFG_IDX_W'(i);
            cfg_data  <= image[i];
            sb.set_register(grf_pkg::CFG_IDX_W'(i), image[i]);
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function bit [15:0] rand_pixel();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function bit [15:0] extreme_weight();
        case ($urandom_range(0, 3))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'd32768;
            default: return 16'hFFFF;
        endcase
    endfunction

    // Stimulus
    initial
    begin
        int        items_sent;
        int        row_left;
        int        n;
        int        h;
        int        mode;
        int        budget;
        bit [15:0] hdata;
        bit [15:0] c [0:MAX_HALF];

        sb          = new();
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        src_idle_on = 1'b1;
        quiet       = 1'b0;
        cycles      = 0;
        items_sent  = 0;
        row_left    = 0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset weights pass pixels straight through
        send_pixel(16'h0000, 1'b0);
        send_pixel(16'hFFFF, 1'b0);
        send_pixel(16'h1234, 1'b1);
        drain_block();

        // Zero half width acts as one; a single pixel row flushes on its own
        load_kernel(16'd0, 16'd16384, 16'd8192, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_pixel(16'hFFFF, 1'b0);
        send_pixel(16'h0000, 1'b0);
        send_pixel(16'h8000, 1'b1);
        send_pixel(16'hABCD, 1'b1);
        drain_block();

        // Half width above the maximum, heavy weights saturate, rows shorter than h
        load_kernel(16'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                    16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(16'hFFFF, 1'b0);
        send_pixel(16'hFFFF, 1'b0);
        send_pixel(16'h0001, 1'b0);
        send_pixel(16'h5555, 1'b1);
        send_pixel(16'h0000, 1'b1);
        drain_block();

        // Widest kernel, then shrink the half width in the middle of the row
        load_kernel(16'd6, 16'd8192, 16'd6144, 16'd4096, 16'd2048,
                    16'd1024, 16'd512, 16'd256);
        repeat (5) send_pixel(rand_pixel(), 1'b0);
        drain_block();
        load_kernel(16'd2, 16'd16384, 16'd4096, 16'd4096, 16'd30000,
                    16'd30000, 16'd30000, 16'd30000);
        send_pixel(rand_pixel(), 1'b0);
        send_pixel(rand_pixel(), 1'b0);
        send_pixel(rand_pixel(), 1'b1);
        drain_block();

        // Rounding at the half-LSB boundary
        load_kernel(16'd1, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_pixel(16'd16384, 1'b0);
        send_pixel(16'd16383, 1'b0);
        send_pixel(16'd49152, 1'b1);
        drain_block();

        // Random phases; a phase boundary may fall inside a row
        while (items_sent < ITEMS)
        begin
            h     = $urandom_range(0, 7);
            hdata = ($urandom_range(0, 3) == 0) ? 16'(($urandom_range(0, 8191) << 3) | h)
                                                : 16'(h);
            mode  = $urandom_range(0, 3);
            case (mode)
                0:
                begin
                    c[0]   = 16'($urandom_range(8192, 32768));
                    budget = 32768 - c[0];
                    for (int d = 1; d <= MAX_HALF; d++)
                    begin
                        c[d]   = 16'($urandom_range(0, budget / 2));
                        budget -= 2 * c[d];
                    end
                end
                1: foreach (c[i]) c[i] = 16'($urandom_range(0, 65535));
                2: foreach (c[i]) c[i] = extreme_weight();
                default:
                begin
                    c[0] = 16'd32768;
                    for (int d = 1; d <= MAX_HALF; d++)
                        c[d] = 16'($urandom_range(0, 2048));
                end
            endcase
            load_kernel(hdata, c[0], c[1], c[2], c[3], c[4], c[5], c[6]);

            quiet       = items_sent >= ITEMS - QUIET_TAIL;
            src_idle_on = !quiet && $urandom_range(0, 2) != 0;

            n = $urandom_range(15, 50);
            repeat (n)
            begin
                if (row_left == 0)
                    row_left = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 40)
                                                           : $urandom_range(1, 12);
                row_left--;
                send_pixel(rand_pixel(), row_left == 0);
                items_sent++;
            end
            drain_block();
        end

        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> filelist.f
rtl/grf_pkg.sv
rtl/grf_cell.sv
rtl/grf_tap.sv
rtl/grf_sum.sv
rtl/gaussian_row_filter_replicate_unit.sv
tb/tb_gaussian_row_filter_replicate_unit.sv
